>>> hdl/wapi_ie_pkg.sv
`timescale 1ns / 1ps

package wapi_ie_pkg;

  localparam int unsigned MIN_ELEMENT_BYTES = 22;
  localparam int unsigned ENTRY_BYTES       = 4;
  localparam int unsigned FIRST_KEY_ENTRY   = 6;
  localparam int unsigned KC_BYTE_LO        = 4;
  localparam int unsigned KC_BYTE_HI        = 5;

  // offsets follow from the 16-bit counts, whatever the element length
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned POFF_W  = 19;
  localparam int unsigned GOFF_W  = 20;

  localparam logic [7:0] OUI_BYTE0 = 8'h00;
  localparam logic [7:0] OUI_BYTE1 = 8'h14;
  localparam logic [7:0] OUI_BYTE2 = 8'h72;

  localparam logic [7:0] TYPE_CERT = 8'h01;
  localparam logic [7:0] TYPE_PSK  = 8'h02;
  localparam logic [7:0] TYPE_WPI  = 8'h01;

  localparam logic [1:0] LAST_PREFIX_K = 2'd2;

  // bit positions in the gathered flag vector
  localparam int unsigned FLAG_CERT  = 0;
  localparam int unsigned FLAG_PSK   = 1;
  localparam int unsigned FLAG_PAIR  = 2;
  localparam int unsigned FLAG_GROUP = 3;

  typedef struct packed {
    logic [7:0] ie_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic key_mgmt_certificate;
    logic key_mgmt_psk;
    logic pairwise_wpi;
    logic group_wpi;
    logic status;
  } result_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  function automatic logic [7:0] oui_byte(input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = OUI_BYTE0;
      2'd1:    v = OUI_BYTE1;
      2'd2:    v = OUI_BYTE2;
      default: v = OUI_BYTE0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/wapi_ie_ifs.sv
`timescale 1ns / 1ps

interface wapi_ie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ie_byte;
  logic       last_byte;

  modport source (output valid, output ie_byte, output last_byte, input ready);
  modport sink (input valid, input ie_byte, input last_byte, output ready);
endinterface

interface wapi_ie_out_if;
  logic valid;
  logic ready;
  logic key_mgmt_certificate;
  logic key_mgmt_psk;
  logic pairwise_wpi;
  logic group_wpi;
  logic status;

  modport source (
    output valid, output key_mgmt_certificate, output key_mgmt_psk,
    output pairwise_wpi, output group_wpi, output status, input ready
  );
  modport sink (
    input valid, input key_mgmt_certificate, input key_mgmt_psk,
    input pairwise_wpi, input group_wpi, input status, output ready
  );
endinterface

>>> hdl/wapi_ie_suite_parser.sv
`timescale 1ns / 1ps

// WAPI information element suite parser.
// in_ch carries the element one byte per item, starting at the element id,
// with last_byte set on the final byte. out_ch carries one result per
// element: certificate and PSK key management, WPI pairwise, WPI group and
// a status bit that flags an element shorter than 22 bytes.
// Every byte passes an input register and is then folded into the parse
// state; the result of the last byte lands in the output register at the
// same edge, so a result is visible once its last byte has passed the input
// register and the output register.
// One byte is taken every cycle unless a last byte waits for the output
// register; per-byte offset compares and counter update feed the parse state.
// Bytes beyond MAX_IE_BYTES are ignored; the element is parsed as if it
// ended there.
// A synchronous low rst_n empties both registers and clears the parse state.
// While out_ch stalls, bytes that are not last still flow in; a last byte
// waits in the input register until the output register is free, and
// in_ch.ready stays low while it waits.
module wapi_ie_suite_parser #(
  parameter int unsigned MAX_IE_BYTES = 257
) (
  input logic          clk,
  input logic          rst_n,
  wapi_ie_in_if.sink   in_ch,
  wapi_ie_out_if.source out_ch
);

  wapi_ie_pkg::in_item_t in_item;
  wapi_ie_pkg::in_item_t stage_item;
  wapi_ie_pkg::hs_t      stage_hs;
  wapi_ie_pkg::result_t  res;
  wapi_ie_pkg::result_t  out_res;
  logic                  stage_take;
  logic                  res_valid;
  logic                  res_free;
  logic                  in_ready;
  logic                  out_valid;

  assign in_item.ie_byte   = in_ch.ie_byte;
  assign in_item.last_byte = in_ch.last_byte;
  assign in_ch.ready       = in_ready;

  // a last byte moves on only when the result register can take it
  assign stage_take = stage_hs.valid && (!stage_item.last_byte || res_free);

  wapi_ie_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .stage_hs   (stage_hs),
    .stage_take (stage_take),
    .stage_item (stage_item)
  );

  wapi_ie_parse #(
    .MAX_IE_BYTES (MAX_IE_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (stage_take),
    .item      (stage_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wapi_ie_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid                = out_valid;
  assign out_ch.key_mgmt_certificate = out_res.key_mgmt_certificate;
  assign out_ch.key_mgmt_psk         = out_res.key_mgmt_psk;
  assign out_ch.pairwise_wpi         = out_res.pairwise_wpi;
  assign out_ch.group_wpi            = out_res.group_wpi;
  assign out_ch.status               = out_res.status;

endmodule

>>> hdl/wapi_ie_in_stage.sv
`timescale 1ns / 1ps

module wapi_ie_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wapi_ie_pkg::in_item_t in_item,
  output wapi_ie_pkg::hs_t    stage_hs,
  input  logic                stage_take,
  output wapi_ie_pkg::in_item_t stage_item
);

  logic                  valid_r;
  logic                  valid_nxt;
  wapi_ie_pkg::in_item_t item_r;

  assign in_ready = !valid_r || stage_take;

  always_comb begin
    valid_nxt = valid_r;
    if (stage_take) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage_hs.valid = valid_r;
  assign stage_hs.ready = in_ready;
  assign stage_item     = item_r;

endmodule

>>> hdl/wapi_ie_parse.sv
`timescale 1ns / 1ps

module wapi_ie_parse #(
  parameter int unsigned MAX_IE_BYTES = 257
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  wapi_ie_pkg::in_item_t item,
  output logic                  res_valid,
  output wapi_ie_pkg::result_t  res
);

  localparam int unsigned POS_W = $clog2(MAX_IE_BYTES + 1);
  localparam int unsigned CMP_W = wapi_ie_pkg::GOFF_W + 1;

  logic [POS_W-1:0]                    pos_r, pos_nxt;
  logic [wapi_ie_pkg::COUNT_W-1:0]     kc_r, kc_nxt;
  logic [wapi_ie_pkg::COUNT_W-1:0]     pc_r, pc_nxt;
  logic [wapi_ie_pkg::POFF_W-1:0]      poff_r, poff_nxt;
  logic [wapi_ie_pkg::GOFF_W-1:0]      goff_r, goff_nxt;
  logic                                oui_ok_r, oui_ok_nxt;
  logic [3:0]                          seen_r, seen_nxt;

  logic [CMP_W-1:0] p_w;
  logic [CMP_W-1:0] poff_w;
  logic [CMP_W-1:0] goff_w;
  logic [CMP_W-1:0] len_w;
  logic [CMP_W-1:0] poff_nxt_w;
  logic [CMP_W-1:0] goff_nxt_w;
  logic             take;
  logic             in_entry;
  logic [1:0]       kind;
  logic [1:0]       k;
  logic [7:0]       b;
  logic             match;
  logic             key_ok;
  logic             pair_ok;
  logic             group_ok;
  logic             too_short;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_PAIR  = 2'd1;
  localparam logic [1:0] KIND_GROUP = 2'd2;

  assign b      = item.ie_byte;
  assign take   = pos_r < POS_W'(MAX_IE_BYTES);
  assign p_w    = CMP_W'(pos_r);
  assign poff_w = CMP_W'(poff_r);
  assign goff_w = CMP_W'(goff_r);

  always_comb begin
    pos_nxt    = pos_r;
    kc_nxt     = kc_r;
    pc_nxt     = pc_r;
    poff_nxt   = poff_r;
    goff_nxt   = goff_r;
    oui_ok_nxt = oui_ok_r;
    seen_nxt   = seen_r;
    in_entry   = 1'b0;
    kind       = KIND_KEY;
    k          = 2'd0;
    match      = 1'b0;

    if (take) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == POS_W'(wapi_ie_pkg::KC_BYTE_LO)) begin
        kc_nxt = {8'h00, b};
      end else if (pos_r == POS_W'(wapi_ie_pkg::KC_BYTE_HI)) begin
        kc_nxt   = {b, kc_r[7:0]};
        poff_nxt = wapi_ie_pkg::POFF_W'(wapi_ie_pkg::FIRST_KEY_ENTRY)
                 + {1'b0, b, kc_r[7:0], 2'b00};
      end else if (pos_r >= POS_W'(wapi_ie_pkg::FIRST_KEY_ENTRY)) begin
        if (p_w < poff_w) begin
          in_entry = 1'b1;
          kind     = KIND_KEY;
          k        = 2'(pos_r[1:0] - 2'(wapi_ie_pkg::FIRST_KEY_ENTRY));
        end else if (p_w == poff_w) begin
          pc_nxt = {8'h00, b};
        end else if (p_w == poff_w + CMP_W'(1)) begin
          pc_nxt   = {b, pc_r[7:0]};
          goff_nxt = wapi_ie_pkg::GOFF_W'(poff_w + CMP_W'(2) + CMP_W'({b, pc_r[7:0], 2'b00}));
        end else if (p_w < goff_w) begin
          in_entry = 1'b1;
          kind     = KIND_PAIR;
          k        = 2'(pos_r[1:0] - poff_r[1:0] - 2'd2);
        end else if (p_w < goff_w + CMP_W'(wapi_ie_pkg::ENTRY_BYTES)) begin
          in_entry = 1'b1;
          kind     = KIND_GROUP;
          k        = 2'(pos_r[1:0] - goff_r[1:0]);
        end
      end
    end

    if (in_entry) begin
      if (k <= wapi_ie_pkg::LAST_PREFIX_K) begin
        match      = (b == wapi_ie_pkg::oui_byte(k));
        oui_ok_nxt = (k == 2'd0) ? match : (oui_ok_r && match);
      end else if (oui_ok_r) begin
        case (kind)
          KIND_KEY: begin
            if (b == wapi_ie_pkg::TYPE_CERT) begin
              seen_nxt[wapi_ie_pkg::FLAG_CERT] = 1'b1;
            end else if (b == wapi_ie_pkg::TYPE_PSK) begin
              seen_nxt[wapi_ie_pkg::FLAG_PSK] = 1'b1;
            end
          end
          KIND_PAIR: begin
            if (b == wapi_ie_pkg::TYPE_WPI) begin
              seen_nxt[wapi_ie_pkg::FLAG_PAIR] = 1'b1;
            end
          end
          KIND_GROUP: begin
            if (b == wapi_ie_pkg::TYPE_WPI) begin
              seen_nxt[wapi_ie_pkg::FLAG_GROUP] = 1'b1;
            end
          end
          default: begin
            seen_nxt = seen_r;
          end
        endcase
      end
    end
  end

  // verdict uses the state as it stands after this byte
  assign len_w      = CMP_W'(pos_nxt);
  assign poff_nxt_w = CMP_W'(poff_nxt);
  assign goff_nxt_w = CMP_W'(goff_nxt);
  assign too_short  = pos_nxt < POS_W'(wapi_ie_pkg::MIN_ELEMENT_BYTES);
  assign key_ok     = poff_nxt_w <= len_w;
  assign pair_ok    = key_ok && (poff_nxt_w + CMP_W'(2) <= len_w) && (goff_nxt_w <= len_w);
  assign group_ok   = pair_ok
                   && (goff_nxt_w + CMP_W'(wapi_ie_pkg::ENTRY_BYTES) <= len_w);

  assign res_valid = step && item.last_byte;
  assign res.status = too_short;
  assign res.key_mgmt_certificate =
    !too_short && key_ok && seen_nxt[wapi_ie_pkg::FLAG_CERT];
  assign res.key_mgmt_psk =
    !too_short && key_ok && seen_nxt[wapi_ie_pkg::FLAG_PSK];
  assign res.pairwise_wpi =
    !too_short && pair_ok && seen_nxt[wapi_ie_pkg::FLAG_PAIR];
  assign res.group_wpi =
    !too_short && group_ok && seen_nxt[wapi_ie_pkg::FLAG_GROUP];

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      pos_r    <= '0;
      kc_r     <= '0;
      pc_r     <= '0;
      poff_r   <= '0;
      goff_r   <= '0;
      oui_ok_r <= 1'b1;
      seen_r   <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      kc_r     <= kc_nxt;
      pc_r     <= pc_nxt;
      poff_r   <= poff_nxt;
      goff_r   <= goff_nxt;
      oui_ok_r <= oui_ok_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

>>> hdl/wapi_ie_out_stage.sv
`timescale 1ns / 1ps

module wapi_ie_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  wapi_ie_pkg::result_t res,
  output logic                 res_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wapi_ie_pkg::result_t out_res
);

  logic                 valid_r;
  logic                 valid_nxt;
  wapi_ie_pkg::result_t res_r;

  assign res_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (res_valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> tb/sv/tb_wapi_ie_suite_parser.sv
`timescale 1ns / 1ps

module tb_wapi_ie_suite_parser;

  localparam int unsigned IE_BYTE_LIMIT    = 257;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned QUIET_LIMIT      = 4000;
  localparam int unsigned PRINT_LIMIT      = 100;
  localparam logic [7:0]  WAPI_OUI [3]     =
    '{wapi_ie_pkg::OUI_BYTE0, wapi_ie_pkg::OUI_BYTE1, wapi_ie_pkg::OUI_BYTE2};

  typedef enum logic [1:0] {LIST_KEY, LIST_PAIR, LIST_GROUP} suite_list_t;

  logic clk = 1'b0;
  logic rst_n;

  wapi_ie_in_if  in_ch ();
  wapi_ie_out_if out_ch ();

  wapi_ie_suite_parser #(
    .MAX_IE_BYTES(IE_BYTE_LIMIT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // parse state of the predictor
  logic [8:0]  ie_pos;
  logic [15:0] akm_count;
  logic [18:0] pair_base;
  logic [15:0] pair_count;
  logic [19:0] group_base;
  logic        oui_match;
  logic [3:0]  suite_seen;

  wapi_ie_pkg::in_item_t ie_bytes_queued[$];
  wapi_ie_pkg::result_t  suite_reports_due[$];
  logic [7:0]            elem[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          pressure_on = 1'b0;
  int unsigned hold_count = 0;
  int unsigned error_count = 0;
  int unsigned reports_seen = 0;
  int unsigned bytes_offered;
  int unsigned elems_offered;

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b want %b", reports_seen, name, got, want));
  endtask

  function automatic void clear_parse_state();
    ie_pos     = '0;
    akm_count  = '0;
    pair_base  = '0;
    pair_count = '0;
    group_base = '0;
    oui_match  = 1'b1;
    suite_seen = '0;
  endfunction

  function automatic void fold_suite_byte(input logic [1:0] k, input logic [7:0] b,
                                          input suite_list_t list);
    logic hit;
    if (k <= wapi_ie_pkg::LAST_PREFIX_K) begin
      hit = (b == WAPI_OUI[k]);
      oui_match = (k == 2'd0) ? hit : (oui_match && hit);
    end else if (oui_match) begin
      case (list)
        LIST_KEY: begin
          if (b == wapi_ie_pkg::TYPE_CERT) suite_seen[wapi_ie_pkg::FLAG_CERT] = 1'b1;
          else if (b == wapi_ie_pkg::TYPE_PSK) suite_seen[wapi_ie_pkg::FLAG_PSK] = 1'b1;
        end
        LIST_PAIR: begin
          if (b == wapi_ie_pkg::TYPE_WPI) suite_seen[wapi_ie_pkg::FLAG_PAIR] = 1'b1;
        end
        default: begin
          if (b == wapi_ie_pkg::TYPE_WPI) suite_seen[wapi_ie_pkg::FLAG_GROUP] = 1'b1;
        end
      endcase
    end
  endfunction

  function automatic void fold_ie_byte(input logic [8:0] p, input logic [7:0] b);
    logic [31:0] pos;
    pos = 32'(p);
    if (pos == wapi_ie_pkg::KC_BYTE_LO) begin
      akm_count = {8'h00, b};
    end else if (pos == wapi_ie_pkg::KC_BYTE_HI) begin
      akm_count[15:8] = b;
      pair_base = 19'(wapi_ie_pkg::FIRST_KEY_ENTRY + wapi_ie_pkg::ENTRY_BYTES * akm_count);
    end else if (pos >= wapi_ie_pkg::FIRST_KEY_ENTRY) begin
      if (pos < pair_base) begin
        fold_suite_byte(2'(pos - wapi_ie_pkg::FIRST_KEY_ENTRY), b, LIST_KEY);
      end else if (pos == pair_base) begin
        pair_count = {8'h00, b};
      end else if (pos == 32'(pair_base) + 1) begin
        pair_count[15:8] = b;
        group_base = 20'(32'(pair_base) + 2 + wapi_ie_pkg::ENTRY_BYTES * pair_count);
      end else if (pos < group_base) begin
        fold_suite_byte(2'(pos - pair_base - 2), b, LIST_PAIR);
      end else if (pos < 32'(group_base) + wapi_ie_pkg::ENTRY_BYTES) begin
        fold_suite_byte(2'(pos - group_base), b, LIST_GROUP);
      end
    end
  endfunction

  function automatic void parse_ie_byte(input wapi_ie_pkg::in_item_t it, output bit done,
                                        output wapi_ie_pkg::result_t res);
    logic [31:0] len;
    logic key_ok, pair_ok, group_ok;
    done = 1'b0;
    res = '0;
    if (ie_pos < IE_BYTE_LIMIT) begin
      fold_ie_byte(ie_pos, it.ie_byte);
      ie_pos++;
    end
    if (it.last_byte) begin
      done = 1'b1;
      len = 32'(ie_pos);
      if (len < wapi_ie_pkg::MIN_ELEMENT_BYTES) begin
        res.status = 1'b1;
      end else begin
        key_ok   = (32'(pair_base) <= len);
        pair_ok  = key_ok && (32'(pair_base) + 2 <= len) && (32'(group_base) <= len);
        group_ok = pair_ok && (32'(group_base) + wapi_ie_pkg::ENTRY_BYTES <= len);
        res.key_mgmt_certificate = key_ok && suite_seen[wapi_ie_pkg::FLAG_CERT];
        res.key_mgmt_psk         = key_ok && suite_seen[wapi_ie_pkg::FLAG_PSK];
        res.pairwise_wpi         = pair_ok && suite_seen[wapi_ie_pkg::FLAG_PAIR];
        res.group_wpi            = group_ok && suite_seen[wapi_ie_pkg::FLAG_GROUP];
      end
      clear_parse_state();
    end
  endfunction

  // sender: one item held until taken, next one from the queue
  always @(posedge clk) begin : byte_driver
    wapi_ie_pkg::in_item_t taken;
    wapi_ie_pkg::in_item_t nxt;
    bit                    done;
    wapi_ie_pkg::result_t  due;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      clear_parse_state();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.ie_byte   = in_ch.ie_byte;
        taken.last_byte = in_ch.last_byte;
        parse_ie_byte(taken, done, due);
        if (done) suite_reports_due.push_back(due);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (ie_bytes_queued.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = ie_bytes_queued.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.ie_byte   <= nxt.ie_byte;
          in_ch.last_byte <= nxt.last_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off once pressure is on
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (pressure_on && hold_count < LONG_HOLD_CYCLES) begin
      out_ch.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    wapi_ie_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (suite_reports_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no element pending", reports_seen));
      end else begin
        want = suite_reports_due.pop_front();
        check_field("key_mgmt_certificate", out_ch.key_mgmt_certificate,
                    want.key_mgmt_certificate);
        check_field("key_mgmt_psk", out_ch.key_mgmt_psk, want.key_mgmt_psk);
        check_field("pairwise_wpi", out_ch.pairwise_wpi, want.pairwise_wpi);
        check_field("group_wpi", out_ch.group_wpi, want.group_wpi);
        check_field("status", out_ch.status, want.status);
      end
      reports_seen++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] pick_type(input suite_list_t list);
    if ($urandom_range(2) == 0) return 8'($urandom);
    if (list == LIST_KEY) return $urandom_range(1) ? wapi_ie_pkg::TYPE_CERT : wapi_ie_pkg::TYPE_PSK;
    return wapi_ie_pkg::TYPE_WPI;
  endfunction

  task automatic push_suite(input suite_list_t list, input int unsigned bad_pct);
    int bad_at;
    bad_at = ($urandom_range(99) < bad_pct) ? int'($urandom_range(2)) : -1;
    for (int i = 0; i < 3; i++)
      elem.push_back((i == bad_at) ? WAPI_OUI[i] ^ 8'($urandom_range(255, 1)) : WAPI_OUI[i]);
    elem.push_back(pick_type(list));
  endtask

  // element with count fields that agree with the lists
  task automatic build_element(input logic [15:0] akm_n, input logic [15:0] pair_n,
                               input bit with_group, input int unsigned tail_n,
                               input int unsigned bad_pct);
    elem.delete();
    elem.push_back(8'h44);
    elem.push_back(8'h00);
    elem.push_back(8'h01);
    elem.push_back(8'h00);
    elem.push_back(akm_n[7:0]);
    elem.push_back(akm_n[15:8]);
    repeat (akm_n) push_suite(LIST_KEY, bad_pct);
    elem.push_back(pair_n[7:0]);
    elem.push_back(pair_n[15:8]);
    repeat (pair_n) push_suite(LIST_PAIR, bad_pct);
    if (with_group) push_suite(LIST_GROUP, bad_pct);
    repeat (tail_n) elem.push_back(8'($urandom));
    elem[1] = 8'(elem.size() - 2);
  endtask

  task automatic fill_noise(input int unsigned n, input logic [7:0] b, input bit rnd);
    elem.delete();
    repeat (n) elem.push_back(rnd ? 8'($urandom) : b);
  endtask

  task automatic queue_element();
    wapi_ie_pkg::in_item_t it;
    foreach (elem[i]) begin
      it.ie_byte   = elem[i];
      it.last_byte = (i == elem.size() - 1);
      ie_bytes_queued.push_back(it);
    end
    bytes_offered += (elem.size() < IE_BYTE_LIMIT) ? elem.size() : IE_BYTE_LIMIT;
    elems_offered++;
  endtask

  task automatic queue_random_element();
    int unsigned pick;
    int unsigned kc;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 70) begin
      kc = $urandom_range(3);
      build_element(16'(kc), 16'($urandom_range(3)), $urandom_range(9) != 0,
                    $urandom_range(6), 15);
      case ($urandom_range(7))
        0: begin
          cut = $urandom_range(elem.size(), 1);
          while (elem.size() > cut) void'(elem.pop_back());
        end
        1: elem[wapi_ie_pkg::KC_BYTE_LO + $urandom_range(1)] = 8'($urandom);
        2: elem[wapi_ie_pkg::FIRST_KEY_ENTRY + wapi_ie_pkg::ENTRY_BYTES * kc
                + $urandom_range(1)] = 8'($urandom);
        3: elem[$urandom_range(elem.size() - 1)] = 8'($urandom);
        default: ;
      endcase
    end else if (pick < 80) begin
      fill_noise($urandom_range(wapi_ie_pkg::MIN_ELEMENT_BYTES - 1, 1), 8'h00, 1'b1);
    end else if (pick < 95) begin
      fill_noise($urandom_range(48, wapi_ie_pkg::MIN_ELEMENT_BYTES), 8'h00, 1'b1);
    end else begin
      build_element(16'($urandom_range(20, 5)), 16'($urandom_range(10)), 1'b1,
                    $urandom_range(30), 10);
    end
    queue_element();
  endtask

  task automatic wait_drained();
    while (ie_bytes_queued.size() != 0 || in_ch.valid || suite_reports_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_random_phase(input int unsigned idle, input int unsigned stall);
    @(negedge clk);
    idle_pct      = idle;
    stall_pct     = stall;
    bytes_offered = 0;
    elems_offered = 0;
    while (bytes_offered < 50 || elems_offered < 3) queue_random_element();
    wait_drained();
  endtask

  task automatic queue_directed();
    // minimum length with every suite present
    build_element(16'd1, 16'd1, 1'b1, 2, 0);
    elem[9] = wapi_ie_pkg::TYPE_CERT;
    elem[15] = wapi_ie_pkg::TYPE_WPI;
    elem[19] = wapi_ie_pkg::TYPE_WPI;
    queue_element();
    // one byte short of the minimum
    build_element(16'd1, 16'd1, 1'b1, 1, 0);
    elem[9] = wapi_ie_pkg::TYPE_CERT;
    elem[15] = wapi_ie_pkg::TYPE_WPI;
    elem[19] = wapi_ie_pkg::TYPE_WPI;
    queue_element();
    // single byte element
    elem = '{8'hff};
    queue_element();
    // both key suites
    build_element(16'd2, 16'd1, 1'b1, 0, 0);
    elem[9] = wapi_ie_pkg::TYPE_CERT;
    elem[13] = wapi_ie_pkg::TYPE_PSK;
    elem[19] = wapi_ie_pkg::TYPE_WPI;
    elem[23] = wapi_ie_pkg::TYPE_WPI;
    queue_element();
    // key list runs past the end
    build_element(16'd1, 16'd1, 1'b1, 4, 0);
    elem[5] = 8'h01;
    elem[9] = wapi_ie_pkg::TYPE_CERT;
    queue_element();
    // pairwise count only half inside
    build_element(16'd4, 16'd0, 1'b0, 0, 0);
    elem[9] = wapi_ie_pkg::TYPE_CERT;
    elem[13] = wapi_ie_pkg::TYPE_PSK;
    void'(elem.pop_back());
    queue_element();
    // pairwise list runs past the end
    build_element(16'd1, 16'd2, 1'b1, 4, 0);
    elem[10] = 8'hff;
    elem[11] = 8'hff;
    elem[15] = wapi_ie_pkg::TYPE_WPI;
    elem[19] = wapi_ie_pkg::TYPE_WPI;
    queue_element();
    // group field cut short
    build_element(16'd2, 16'd1, 1'b1, 0, 0);
    elem[19] = wapi_ie_pkg::TYPE_WPI;
    void'(elem.pop_back());
    void'(elem.pop_back());
    queue_element();
    // empty lists, group only
    build_element(16'd0, 16'd0, 1'b1, 12, 0);
    elem[11] = wapi_ie_pkg::TYPE_WPI;
    queue_element();
    // every prefix wrong
    build_element(16'd2, 16'd2, 1'b1, 0, 100);
    queue_element();
    // known prefix, unknown types
    build_element(16'd1, 16'd1, 1'b1, 2, 0);
    elem[9] = 8'h03;
    elem[15] = wapi_ie_pkg::TYPE_PSK;
    elem[19] = 8'hff;
    queue_element();
    // overlong element, group field beyond the bytes that are kept
    build_element(16'd62, 16'd0, 1'b1, 0, 0);
    elem[9] = wapi_ie_pkg::TYPE_PSK;
    queue_element();
    fill_noise(30, 8'hff, 1'b0);
    queue_element();
    fill_noise(wapi_ie_pkg::MIN_ELEMENT_BYTES, 8'h00, 1'b0);
    queue_element();
  endtask

  initial begin : main_seq
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    queue_directed();
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(68, 0);
    run_random_phase(0, 68);
    run_random_phase(38, 38);

    // receiver holds off while the sender keeps offering
    @(negedge clk);
    idle_pct    = 0;
    stall_pct   = 0;
    pressure_on = 1'b1;
    repeat (6) begin
      build_element(16'($urandom_range(3)), 16'($urandom_range(3)), 1'b1, 2, 10);
      queue_element();
    end
    wait_drained();

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
